>>> sv/hidfl_pkg.sv
// Shared types, constants and helper functions of the HID descriptor field locator.
// No dependencies; imported by every other file of the block except hidfl_ram.
package hidfl_pkg;

  // Sizing
  localparam int NUM_BUTTONS         = 32;
  localparam int USAGE_QUEUE_DEPTH   = 16;
  localparam int MAX_FIELDS_PER_ITEM = 64;

  localparam int NCAND = NUM_BUTTONS + 4;             // X, Y, Wheel, buttons, Pan
  localparam int KW    = $clog2(NCAND);
  localparam int QAW   = (USAGE_QUEUE_DEPTH > 1) ? $clog2(USAGE_QUEUE_DEPTH) : 1;
  localparam int QFW   = $clog2(USAGE_QUEUE_DEPTH + 1);
  localparam int RNW   = $clog2(MAX_FIELDS_PER_ITEM + 1);
  localparam int OFS_DEPTH = 256;

  // Item tags (prefix with the size bits masked off)
  localparam logic [7:0] TAG_MASK      = 8'hFC;
  localparam logic [7:0] TAG_INPUT     = 8'h80;
  localparam logic [7:0] TAG_OUTPUT    = 8'h90;
  localparam logic [7:0] TAG_COLL      = 8'hA0;
  localparam logic [7:0] TAG_FEATURE   = 8'hB0;
  localparam logic [7:0] TAG_PAGE      = 8'h04;
  localparam logic [7:0] TAG_RSIZE     = 8'h74;
  localparam logic [7:0] TAG_RID       = 8'h84;
  localparam logic [7:0] TAG_RCOUNT    = 8'h94;
  localparam logic [7:0] TAG_USAGE     = 8'h08;
  localparam logic [7:0] TAG_USAGE_MIN = 8'h18;
  localparam logic [7:0] TAG_USAGE_MAX = 8'h28;

  localparam logic [1:0] SIZE_FOUR     = 2'b11;
  localparam logic [1:0] MAIN_DATA_VAR = 2'b10;

  // Usages of interest
  localparam logic [15:0] PAGE_BUTTON = 16'h0009;
  localparam logic [31:0] USAGE_X     = 32'h0001_0030;
  localparam logic [31:0] USAGE_Y     = 32'h0001_0031;
  localparam logic [31:0] USAGE_WHEEL = 32'h0001_0038;
  localparam logic [31:0] USAGE_PAN   = 32'h000C_0238;

  localparam logic KIND_BUTTON = 1'b0;
  localparam logic KIND_AXIS   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_RANGE,
    ST_QREAD,
    ST_QPLACE,
    ST_TINIT,
    ST_TAIL,
    ST_DRAIN,
    ST_OFFS
  } state_t;

  typedef struct packed {
    logic accept;
    logic base_ld;
    logic range_step;
    logic q_step;
    logic tail_init;
    logic tail_step;
    logic drain;
    logic offs;
  } cmd_t;

  typedef struct packed {
    logic input_run;
    logic data_var;
    logic range_mode;
    logic q_none;
    logic q_empty;
    logic range_last;
    logic q_last;
    logic tail_done;
    logic stall;
    logic pend_v;
  } sts_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  index;
    logic [7:0]  rpt_id;
    logic [15:0] bit_pos;
    logic [15:0] size;
    logic        uses_ids;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic       kind;
    logic [7:0] idx;
  } cls_t;

  // Map a usage to a button or an axis target
  function automatic cls_t classify(input logic [31:0] u);
    cls_t c;
    c = '0;
    if (u[31:16] == PAGE_BUTTON) begin
      c.kind = KIND_BUTTON;
      c.idx  = 8'(u[15:0] - 16'd1);
      c.hit  = (u[15:0] != 16'd0) && (u[15:0] <= 16'(NUM_BUTTONS));
    end else begin
      c.kind = KIND_AXIS;
      case (u)
        USAGE_X:     begin c.hit = 1'b1; c.idx = 8'd0; end
        USAGE_Y:     begin c.hit = 1'b1; c.idx = 8'd1; end
        USAGE_WHEEL: begin c.hit = 1'b1; c.idx = 8'd2; end
        USAGE_PAN:   begin c.hit = 1'b1; c.idx = 8'd3; end
        default:     c.hit = 1'b0;
      endcase
    end
    return c;
  endfunction

  // Range walk candidates in ascending usage order
  function automatic logic [31:0] cand(input logic [KW-1:0] k);
    logic [31:0] r;
    if (k == KW'(0))      r = USAGE_X;
    else if (k == KW'(1)) r = USAGE_Y;
    else if (k == KW'(2)) r = USAGE_WHEEL;
    else if (k == KW'(NCAND - 1)) r = USAGE_PAN;
    else r = {PAGE_BUTTON, 16'(k) - 16'd2};
    return r;
  endfunction

endpackage

>>> sv/hid_report_descriptor_field_locator.sv
// Top level of the HID report descriptor field locator.
// Depends on hidfl_pkg, hidfl_ctrl, hidfl_dp (and hidfl_ram through hidfl_dp).
//
// Takes a HID report descriptor one byte per transfer and emits one placement item for
// each button or axis field of every Data/Variable Input item, up to MAX_FIELDS_PER_ITEM
// per item. A byte that completes an Input item adds an offset fetch and an offset
// update, and no new byte is taken until that update. With Data/Variable set and usages
// present the walk, run by the single shared field-step unit, first either steps through
// the NUM_BUTTONS+4 candidates of a usage minimum/maximum range or reads and places each
// queued usage (usage queue read port), then places the repeated fields and drains a placement
// left pending at the end; stalls on the output side hold it. The per-report-ID offset
// table is cleared at once by valid bits on reset and on start_of_descriptor, with no
// clearing pass.
module hid_report_descriptor_field_locator
  import hidfl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] desc_byte
  input  logic        in_tuser,   // start_of_descriptor
  input  logic        in_tlast,   // end_of_descriptor
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] target_index, [15:8] placed_report_id,
                                  // [31:16] bit_position, [47:32] field_size,
                                  // [48] uses_report_ids, [55:49] zero
  output logic        out_tuser,  // target_kind
  output logic        out_tlast   // last_of_run
);

  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic res_last_r;

  hidfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hidfl_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_start   (in_tuser),
    .in_end     (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  // Mark the last item of a run: loaded with the item when it moves out of pending
  always_ff @(posedge clk) begin
    if (sts.pend_v && (!out_tvalid || out_tready) && (cmd.drain || cmd.range_step ||
        cmd.q_step || cmd.tail_step) && !sts.stall) begin
      res_last_r <= cmd.drain;
    end
  end

  assign out_tdata = {7'd0, res.uses_ids, res.size, res.bit_pos, res.rpt_id, res.index};
  assign out_tuser = res.kind;
  assign out_tlast = res_last_r;

endmodule

>>> sv/hidfl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hidfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hidfl_ctrl.sv
// Controller of the HID descriptor field locator: sequences byte parsing and field walks.
// Depends on hidfl_pkg.
module hidfl_ctrl
  import hidfl_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_tvalid,
  output logic   in_tready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && sts.input_run) state_nxt = ST_BASE;
      end
      ST_BASE: begin
        if (!sts.data_var)      state_nxt = ST_OFFS;
        else if (sts.range_mode) state_nxt = ST_RANGE;
        else if (sts.q_none)    state_nxt = ST_OFFS;
        else if (sts.q_empty)   state_nxt = ST_TINIT;
        else                    state_nxt = ST_QREAD;
      end
      ST_RANGE: begin
        if (!sts.stall && sts.range_last) state_nxt = ST_TINIT;
      end
      ST_QREAD: state_nxt = ST_QPLACE;
      ST_QPLACE: begin
        if (!sts.stall) state_nxt = sts.q_last ? ST_TINIT : ST_QREAD;
      end
      ST_TINIT: state_nxt = ST_TAIL;
      ST_TAIL: begin
        if (sts.tail_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pend_v) state_nxt = ST_OFFS;
      end
      ST_OFFS: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_BASE:   cmd.base_ld    = 1'b1;
      ST_RANGE:  cmd.range_step = 1'b1;
      ST_QREAD:  cmd            = '0;
      ST_QPLACE: cmd.q_step     = 1'b1;
      ST_TINIT:  cmd.tail_init  = 1'b1;
      ST_TAIL:   cmd.tail_step  = 1'b1;
      ST_DRAIN:  cmd.drain      = 1'b1;
      ST_OFFS:   cmd.offs       = 1'b1;
      default:   cmd            = '0;
    endcase
  end

endmodule

>>> sv/hidfl_dp.sv
// Datapath of the HID descriptor field locator: item parser, parser state, field walk,
// offset table, usage queue and result staging. Depends on hidfl_pkg and hidfl_ram.
module hidfl_dp
  import hidfl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_start,
  input  logic       in_end,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_tvalid,
  input  logic       out_tready,
  output res_t       out_res
);

  // Parser and descriptor state
  logic [7:0]     prefix_r, prefix_nxt;
  logic [2:0]     left_r, left_nxt;
  logic [2:0]     taken_r, taken_nxt;
  logic [31:0]    acc_r, acc_nxt;
  logic [7:0]     rid_r, rid_nxt;
  logic [31:0]    bits_r, bits_nxt;
  logic [31:0]    count_r, count_nxt;
  logic [15:0]    page_r, page_nxt;
  logic [QFW-1:0] fill_r, fill_nxt;
  logic [31:0]    low_r, low_nxt;
  logic [31:0]    high_r, high_nxt;
  logic [31:0]    lastu_r, lastu_nxt;
  logic           flag_r, flag_nxt;
  logic [OFS_DEPTH-1:0] vld_r, vld_nxt;

  // Walk state
  logic [15:0]    base_r, base_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [QAW-1:0] qi_r, qi_nxt;
  logic [31:0]    ti_r, ti_nxt;
  logic [31:0]    tu_r, tu_nxt;
  logic [RNW-1:0] resn_r, resn_nxt;
  logic           pend_v_r, pend_v_nxt;
  res_t           pend_r, pend_nxt;
  logic           out_v_r, out_v_nxt;
  res_t           out_r, out_nxt;

  // Memory ports
  logic           q_we;
  logic [31:0]    q_wdata;
  logic [31:0]    q_rdata;
  logic           o_we;
  logic [15:0]    o_wdata;
  logic [15:0]    o_rdata;

  // Parse working values
  logic [2:0]     e_left, e_taken;
  logic [31:0]    e_acc, v, full;
  logic [QFW-1:0] e_fill;
  logic [15:0]    e_page;
  logic [7:0]     tag;
  logic           run;

  // Walk working values
  logic [31:0]    span, tail_u, c, c_off, place_u, place_f;
  logic [QFW-1:0] n;
  logic           rcond, hit_ok, push, move, out_free, stall, res_room;
  cls_t           pcls, tcls;
  res_t           new_res;

  hidfl_ram #(.WIDTH(32), .DEPTH(USAGE_QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (e_fill[QAW-1:0]),
    .wdata (q_wdata),
    .raddr (qi_r),
    .rdata (q_rdata)
  );

  hidfl_ram #(.WIDTH(16), .DEPTH(OFS_DEPTH)) u_offs (
    .clk   (clk),
    .we    (o_we),
    .waddr (rid_r),
    .wdata (o_wdata),
    .raddr (rid_r),
    .rdata (o_rdata)
  );

  // Walk helpers
  always_comb begin
    span     = (high_r > low_r) ? high_r - low_r : 32'd0;
    tail_u   = (high_r > low_r) ? high_r : low_r;
    n        = (32'(fill_r) < count_r) ? fill_r : QFW'(count_r);
    c        = cand(k_r);
    c_off    = c - low_r;
    rcond    = (c >= low_r) && (c_off < span) && (c_off < count_r);
    res_room = resn_r < RNW'(MAX_FIELDS_PER_ITEM);
    tcls     = classify(tu_r);
    out_free = !out_v_r || out_tready;
    stall    = pend_v_r && !out_free;
    if (cmd.range_step) begin
      place_u = c;
      place_f = c_off;
    end else if (cmd.q_step) begin
      place_u = q_rdata;
      place_f = 32'(qi_r);
    end else begin
      place_u = tu_r;
      place_f = ti_r;
    end
    pcls   = classify(place_u);
    hit_ok = pcls.hit && res_room;
    push   = !stall && hit_ok &&
             ((cmd.range_step && rcond) || cmd.q_step ||
              (cmd.tail_step && (ti_r < count_r)));
    move   = pend_v_r && out_free && (push || cmd.drain);
    new_res.kind      = pcls.kind;
    new_res.index     = pcls.idx;
    new_res.rpt_id    = rid_r;
    new_res.bit_pos   = base_r + place_f[15:0] * bits_r[15:0];
    new_res.size      = (pcls.kind == KIND_AXIS) ? bits_r[15:0] : 16'd0;
    new_res.uses_ids  = flag_r;
  end

  // Parse one byte; run short items; update walk and result staging
  always_comb begin
    prefix_nxt = prefix_r;
    left_nxt   = left_r;
    taken_nxt  = taken_r;
    acc_nxt    = acc_r;
    rid_nxt    = rid_r;
    bits_nxt   = bits_r;
    count_nxt  = count_r;
    page_nxt   = page_r;
    fill_nxt   = fill_r;
    low_nxt    = low_r;
    high_nxt   = high_r;
    lastu_nxt  = lastu_r;
    flag_nxt   = flag_r;
    vld_nxt    = vld_r;
    base_nxt   = base_r;
    k_nxt      = k_r;
    qi_nxt     = qi_r;
    ti_nxt     = ti_r;
    tu_nxt     = tu_r;
    resn_nxt   = resn_r;
    q_we       = 1'b0;
    o_we       = 1'b0;
    o_wdata    = base_r + bits_r[15:0] * count_r[15:0];
    run        = 1'b0;
    tag        = prefix_r & TAG_MASK;
    v          = acc_r;

    e_left  = in_start ? 3'd0 : left_r;
    e_taken = in_start ? 3'd0 : taken_r;
    e_acc   = in_start ? 32'd0 : acc_r;
    e_fill  = in_start ? '0 : fill_r;
    e_page  = in_start ? 16'd0 : page_r;
    e_acc   = e_acc | (32'(in_byte) << {e_taken[1:0], 3'b000});
    full    = (e_taken + 3'd1 <= 3'd2) ? {e_page, e_acc[15:0]} : e_acc;
    q_wdata = full;

    if (cmd.accept) begin
      if (in_start) begin
        prefix_nxt = '0; left_nxt = '0; taken_nxt = '0; acc_nxt = '0;
        rid_nxt = '0; bits_nxt = '0; count_nxt = '0; page_nxt = '0;
        fill_nxt = '0; low_nxt = '0; high_nxt = '0; flag_nxt = 1'b0;
        vld_nxt = '0;
      end
      if (e_left == 3'd0) begin
        if (!(in_byte == 8'd0 && in_end)) begin
          prefix_nxt = in_byte;
          acc_nxt    = 32'd0;
          taken_nxt  = 3'd0;
          left_nxt   = (in_byte[1:0] == SIZE_FOUR) ? 3'd4 : {1'b0, in_byte[1:0]};
          tag        = in_byte & TAG_MASK;
          v          = 32'd0;
          full       = {e_page, 16'd0};
          q_wdata    = full;
          run        = (in_byte[1:0] == 2'b00);
        end
      end else begin
        acc_nxt   = e_acc;
        taken_nxt = e_taken + 3'd1;
        left_nxt  = e_left - 3'd1;
        tag       = prefix_r & TAG_MASK;
        v         = e_acc;
        run       = (e_left == 3'd1);
      end
      if (run) begin
        case (tag)
          TAG_OUTPUT, TAG_COLL, TAG_FEATURE: begin
            fill_nxt = '0; low_nxt = '0; high_nxt = '0;
          end
          TAG_PAGE:   page_nxt  = v[15:0];
          TAG_RSIZE:  bits_nxt  = v;
          TAG_RID: begin
            rid_nxt  = v[7:0];
            flag_nxt = 1'b1;
          end
          TAG_RCOUNT: count_nxt = v;
          TAG_USAGE: begin
            if (e_fill < QFW'(USAGE_QUEUE_DEPTH)) begin
              q_we      = 1'b1;
              fill_nxt  = e_fill + QFW'(1);
              lastu_nxt = full;
            end
          end
          TAG_USAGE_MIN: low_nxt  = full;
          TAG_USAGE_MAX: high_nxt = full;
          default: ;
        endcase
      end
      if (in_end) left_nxt = 3'd0;
    end

    // Latch the report base and restart the walk
    if (cmd.base_ld) begin
      base_nxt = vld_r[rid_r] ? o_rdata : 16'd0;
      k_nxt    = '0;
      qi_nxt   = '0;
      resn_nxt = '0;
    end
    if (cmd.range_step && !stall) k_nxt = k_r + KW'(1);
    if (cmd.q_step && !stall) qi_nxt = qi_r + QAW'(1);
    if (cmd.tail_init) begin
      ti_nxt = sts.range_mode ? span : 32'(fill_r);
      tu_nxt = sts.range_mode ? tail_u : lastu_r;
    end
    if (cmd.tail_step && push) ti_nxt = ti_r + 32'd1;
    if (push) resn_nxt = resn_r + RNW'(1);

    // Advance the report offset and clear locals
    if (cmd.offs) begin
      o_we         = 1'b1;
      vld_nxt[rid_r] = 1'b1;
      fill_nxt     = '0;
      low_nxt      = '0;
      high_nxt     = '0;
    end

    // Result staging: pending item feeds the output register
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r;
    if (move) begin
      out_nxt         = pend_r;
      out_v_nxt       = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (push) begin
      pend_nxt   = new_res;
      pend_v_nxt = 1'b1;
    end else if (move) begin
      pend_v_nxt = 1'b0;
    end
  end

  // Status to the controller
  always_comb begin
    sts.input_run  = 1'b0;
    if (e_left == 3'd0) begin
      sts.input_run = !(in_byte == 8'd0 && in_end) && (in_byte[1:0] == 2'b00) &&
                      ((in_byte & TAG_MASK) == TAG_INPUT);
    end else begin
      sts.input_run = (e_left == 3'd1) && ((prefix_r & TAG_MASK) == TAG_INPUT);
    end
    sts.data_var   = (acc_r[1:0] == MAIN_DATA_VAR);
    sts.range_mode = (low_r != 32'd0) && (high_r != 32'd0);
    sts.q_none     = (fill_r == '0);
    sts.q_empty    = (n == '0);
    sts.range_last = (k_r == KW'(NCAND - 1));
    sts.q_last     = ({1'b0, qi_r} + (QAW + 1)'(1)) == (QAW + 1)'(n);
    sts.tail_done  = !((ti_r < count_r) && res_room && tcls.hit);
    sts.stall      = stall;
    sts.pend_v     = pend_v_r;
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
      left_r   <= '0;
      taken_r  <= '0;
      acc_r    <= '0;
      rid_r    <= '0;
      bits_r   <= '0;
      count_r  <= '0;
      page_r   <= '0;
      fill_r   <= '0;
      low_r    <= '0;
      high_r   <= '0;
      flag_r   <= 1'b0;
      vld_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      resn_r   <= '0;
    end else begin
      prefix_r <= prefix_nxt;
      left_r   <= left_nxt;
      taken_r  <= taken_nxt;
      acc_r    <= acc_nxt;
      rid_r    <= rid_nxt;
      bits_r   <= bits_nxt;
      count_r  <= count_nxt;
      page_r   <= page_nxt;
      fill_r   <= fill_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      flag_r   <= flag_nxt;
      vld_r    <= vld_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      resn_r   <= resn_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lastu_r <= lastu_nxt;
    base_r  <= base_nxt;
    k_r     <= k_nxt;
    qi_r    <= qi_nxt;
    ti_r    <= ti_nxt;
    tu_r    <= tu_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_res    = out_r;

  // Checks
  a_resn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    resn_r <= RNW'(MAX_FIELDS_PER_ITEM))
    else $error("result count above limit");
  a_offs_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.offs |-> !pend_v_r)
    else $error("offset update with a result still pending");
  a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !pend_v_r)
    else $error("byte taken with a result still pending");
  a_qi_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_step |-> (QFW + 1)'(qi_r) < (QFW + 1)'(fill_r))
    else $error("queue read beyond fill");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the HID report descriptor field locator.
// Depends on hidfl_pkg and hid_report_descriptor_field_locator; feeds descriptor bytes
// and compares every placement item with a predictor kept in a scoreboard class.
module tb_top;
  import hidfl_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    res_t r;
    logic last;
  } placement_t;

  // Predictor of placements plus the store of placements still to come
  class placement_board;
    logic [7:0]  prefix_reg;
    int unsigned bytes_due;
    int unsigned bytes_got;
    logic [31:0] acc;
    logic [7:0]  rid;
    logic [31:0] rsize;
    logic [31:0] rcount;
    logic [15:0] page;
    logic [31:0] uq [USAGE_QUEUE_DEPTH];
    int unsigned uq_fill;
    logic [31:0] umin;
    logic [31:0] umax;
    logic [15:0] offsets [256];
    logic        rid_seen;
    logic [15:0] base;
    placement_t  run [$];
    placement_t  expected_placements [$];
    int          mismatches;
    int          placements_seen;

    function void clear_parser();
      prefix_reg = '0; bytes_due = 0; bytes_got = 0; acc = '0; rid = '0;
      rsize = '0; rcount = '0; page = '0; uq_fill = 0; umin = '0; umax = '0;
      rid_seen = 1'b0;
      foreach (offsets[i]) offsets[i] = '0;
    endfunction

    function bit target_of(logic [31:0] u, output logic kind, output logic [7:0] idx);
      kind = KIND_AXIS;
      idx  = '0;
      if (u[31:16] == PAGE_BUTTON) begin
        kind = KIND_BUTTON;
        idx  = u[7:0] - 8'd1;
        return (u[15:0] >= 16'd1) && (u[15:0] <= 16'(NUM_BUTTONS));
      end
      case (u)
        USAGE_X:     idx = 8'd0;
        USAGE_Y:     idx = 8'd1;
        USAGE_WHEEL: idx = 8'd2;
        USAGE_PAN:   idx = 8'd3;
        default:     return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void place(logic [31:0] u, logic [31:0] field);
      placement_t p;
      logic       kind;
      logic [7:0] idx;
      logic [31:0] pos;
      if (!target_of(u, kind, idx) || run.size() >= MAX_FIELDS_PER_ITEM) return;
      pos = 32'(base) + field * rsize;
      p.r.kind      = kind;
      p.r.index     = idx;
      p.r.rpt_id    = rid;
      p.r.bit_pos   = pos[15:0];
      p.r.size      = (kind == KIND_AXIS) ? rsize[15:0] : 16'd0;
      p.r.uses_ids  = rid_seen;
      p.last        = 1'b0;
      run.insert(run.size(), p);
    endfunction

    // Fields from first up to the report count all carry usage u
    function void fill_tail(logic [31:0] u, logic [31:0] first);
      logic       kind;
      logic [7:0] idx;
      if (!target_of(u, kind, idx)) return;
      for (logic [31:0] i = first; i < rcount && run.size() < MAX_FIELDS_PER_ITEM; i++)
        place(u, i);
    endfunction

    function void try_usage(logic [31:0] c, logic [31:0] span);
      if (c >= umin && c - umin < span && c - umin < rcount) place(c, c - umin);
    endfunction

    function void walk_min_max();
      logic [31:0] span;
      span = (umax > umin) ? umax - umin : 32'd0;
      try_usage(USAGE_X, span);
      try_usage(USAGE_Y, span);
      try_usage(USAGE_WHEEL, span);
      for (int b = 1; b <= NUM_BUTTONS; b++) try_usage({PAGE_BUTTON, 16'(b)}, span);
      try_usage(USAGE_PAN, span);
      fill_tail((umax > umin) ? umax : umin, span);
    endfunction

    function void walk_usages();
      logic [31:0] n;
      n = (uq_fill < rcount) ? uq_fill : rcount;
      for (logic [31:0] i = 0; i < n; i++) place(uq[i], i);
      fill_tail(uq[uq_fill - 1], uq_fill);
    endfunction

    function void finish_item();
      logic [7:0]  tag;
      logic [31:0] full;
      logic [31:0] grown;
      tag  = prefix_reg & TAG_MASK;
      full = (bytes_got <= 2) ? {page, acc[15:0]} : acc;
      case (tag)
        TAG_INPUT: begin
          base = offsets[rid];
          if (acc[1:0] == MAIN_DATA_VAR) begin
            if (umin != 0 && umax != 0) walk_min_max();
            else if (uq_fill != 0) walk_usages();
          end
          grown = 32'(base) + rsize * rcount;
          offsets[rid] = grown[15:0];
          uq_fill = 0; umin = '0; umax = '0;
        end
        TAG_OUTPUT, TAG_COLL, TAG_FEATURE: begin
          uq_fill = 0; umin = '0; umax = '0;
        end
        TAG_PAGE:   page = acc[15:0];
        TAG_RSIZE:  rsize = acc;
        TAG_RID: begin
          rid = acc[7:0];
          rid_seen = 1'b1;
        end
        TAG_RCOUNT: rcount = acc;
        TAG_USAGE: begin
          if (uq_fill < USAGE_QUEUE_DEPTH) begin
            uq[uq_fill] = full;
            uq_fill++;
          end
        end
        TAG_USAGE_MIN: umin = full;
        TAG_USAGE_MAX: umax = full;
        default: ;
      endcase
    endfunction

    // Note one accepted descriptor byte and queue the placements it causes
    function void note_byte(logic [7:0] b, logic sod, logic eod);
      run.delete();
      if (sod) clear_parser();
      if (bytes_due == 0) begin
        if (!(b == 8'd0 && eod)) begin
          prefix_reg = b;
          acc = '0;
          bytes_got = 0;
          bytes_due = (b[1:0] == SIZE_FOUR) ? 4 : b[1:0];
          if (bytes_due == 0) finish_item();
        end
      end else begin
        acc |= 32'(b) << (8 * (bytes_got % 4));
        bytes_got++;
        bytes_due--;
        if (bytes_due == 0) finish_item();
      end
      if (eod) bytes_due = 0;
      if (run.size() > 0) run[run.size() - 1].last = 1'b1;
      foreach (run[i]) expected_placements.insert(expected_placements.size(), run[i]);
    endfunction

    // Compare one accepted placement item with the oldest expected one
    function void check_placement(logic [55:0] data, logic kind, logic last);
      placement_t e;
      placements_seen++;
      if (expected_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected placement: tdata=%h tuser=%b tlast=%b", data, kind, last);
        return;
      end
      e = expected_placements[0];
      expected_placements.delete(0);
      if (data[7:0] !== e.r.index || data[15:8] !== e.r.rpt_id ||
          data[31:16] !== e.r.bit_pos || data[47:32] !== e.r.size ||
          data[48] !== e.r.uses_ids || data[55:49] !== 7'd0 ||
          kind !== e.r.kind || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Placement mismatch: exp kind=%b idx=%0d rid=%0d pos=%0d size=%0d",
                   e.r.kind, e.r.index, e.r.rpt_id, e.r.bit_pos, e.r.size);
          $display("  exp ids=%b last=%b, got kind=%b idx=%0d rid=%0d pos=%0d",
                   e.r.uses_ids, e.last, kind, data[7:0], data[15:8], data[31:16]);
          $display("  got size=%0d ids=%b last=%b pad=%h",
                   data[47:32], data[48], last, data[55:49]);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] desc_byte
  logic        in_tuser = 1'b0; // start_of_descriptor
  logic        in_tlast = 1'b0; // end_of_descriptor
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // [7:0] index, [15:8] report id, [31:16] bit position,
                                // [47:32] size, [48] uses report ids
  logic        out_tuser;       // target_kind
  logic        out_tlast;       // last_of_run

  placement_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  hid_report_descriptor_field_locator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Take placement items and stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_placement(out_tdata, out_tuser, out_tlast);
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic sod = 1'b0,
                           input logic eod = 1'b0);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sod;
    in_tlast  <= eod;
    do @(posedge clk); while (!in_tready);
    board.note_byte(b, sod, eod);
    bytes_sent++;
  endtask

  // Send a short item: tag with size code and little-endian data
  task automatic push_item(input logic [7:0] tag, input logic [1:0] code,
                           input logic [31:0] value, input logic sod = 1'b0);
    int n;
    n = (code == SIZE_FOUR) ? 4 : code;
    push_byte(tag | 8'(code), sod);
    for (int i = 0; i < n; i++) push_byte(value[8*i +: 8]);
  endtask

  function automatic logic [1:0] code_for(logic [31:0] v);
    if ($urandom_range(9) == 0) return 2'($urandom_range(3));
    if (v < 32'h100) return 2'd1;
    if (v < 32'h10000) return 2'd2;
    return SIZE_FOUR;
  endfunction

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.expected_placements.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_usage();
    case ($urandom_range(6))
      0: return 32'h30 + $urandom_range(1);
      1: return 32'h38;
      2: return 32'h238;
      3: return $urandom_range(NUM_BUTTONS + 2);
      4: return {PAGE_BUTTON, 16'($urandom_range(NUM_BUTTONS))};
      5: return USAGE_PAN;
      default: return $urandom;
    endcase
  endfunction

  // One random item, mostly well formed
  task automatic push_random_item();
    logic [31:0] v;
    case ($urandom_range(15))
      0, 1: begin
        v = $urandom_range(3) == 0 ? $urandom : 32'(($urandom_range(2) == 0) ? 1 :
             ($urandom_range(1) ? 9 : 12));
        push_item(TAG_PAGE, code_for(v), v);
      end
      2, 3, 4: begin
        v = pick_usage();
        push_item(TAG_USAGE, code_for(v), v);
      end
      5: begin
        v = pick_usage();
        push_item(TAG_USAGE_MIN, code_for(v), v);
        v = v + $urandom_range(40);
        push_item(TAG_USAGE_MAX, code_for(v), v);
      end
      6: begin
        v = $urandom_range(15) == 0 ? $urandom : $urandom_range(16);
        push_item(TAG_RSIZE, code_for(v), v);
      end
      7: begin
        v = $urandom_range(15) == 0 ? $urandom : $urandom_range(40);
        push_item(TAG_RCOUNT, code_for(v), v);
      end
      8: begin
        v = $urandom_range(255);
        push_item(TAG_RID, code_for(v), v);
      end
      9, 10, 11: begin
        v = $urandom_range(4) == 0 ? $urandom : 32'(MAIN_DATA_VAR);
        push_item(TAG_INPUT, code_for(v), v);
      end
      12: push_item($urandom_range(1) ? TAG_COLL : TAG_FEATURE, 2'd1, $urandom);
      13: push_item(TAG_OUTPUT, 2'd1, $urandom);
      14: push_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
      default: push_byte(8'($urandom), 1'($urandom_range(1)), 1'b0);
    endcase
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: axes, button range, report ids, four-byte usage, truncation, trailing zero
    push_item(TAG_PAGE, 2'd1, 32'h01, 1'b1);
    push_item(TAG_USAGE, 2'd1, 32'h30);
    push_item(TAG_USAGE, 2'd1, 32'h31);
    push_item(TAG_USAGE, 2'd1, 32'h38);
    push_item(TAG_RSIZE, 2'd1, 32'h08);
    push_item(TAG_RCOUNT, 2'd1, 32'h05);
    push_item(TAG_INPUT, 2'd1, 32'h02);
    push_item(TAG_RID, 2'd1, 32'hFF);
    push_item(TAG_PAGE, 2'd1, 32'h09);
    push_item(TAG_USAGE_MIN, 2'd1, 32'h00);
    push_item(TAG_USAGE_MAX, 2'd1, 32'hFF);
    push_item(TAG_USAGE_MIN, 2'd1, 32'h01);
    push_item(TAG_RSIZE, 2'd1, 32'h01);
    push_item(TAG_RCOUNT, 2'd1, 32'hFF);
    push_item(TAG_INPUT, 2'd0, 32'h0);
    push_item(TAG_USAGE, 2'd1, 32'h00);
    push_item(TAG_INPUT, 2'd1, 32'h02);
    push_item(TAG_USAGE, SIZE_FOUR, USAGE_PAN);
    push_item(TAG_USAGE, 2'd2, 32'hFFFF);
    push_item(TAG_RSIZE, SIZE_FOUR, 32'hFFFF_FFFF);
    push_item(TAG_INPUT, 2'd1, 32'h02);
    push_byte(TAG_RSIZE | 8'd2);
    push_byte(8'h10, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    hold_until_drained();

    // Random descriptors under three handshake regimes
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 32 : (phase == 1) ? 86 : 0;
      recv_idle = (phase == 0) ? 86 : (phase == 1) ? 32 : 0;
      push_item(TAG_PAGE, 2'd1, 32'h01, 1'b1);
      for (int i = 0; i < 3; i++) push_random_item();
      hold_until_drained();
      for (int i = 0; i < 3; i++) push_random_item();
      push_byte(8'h00, 1'b0, 1'b1);
    end
    in_tvalid <= 1'b0;

    while (board.expected_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.expected_placements.size() != 0) board.mismatches++;

    $display("Fed %0d descriptor bytes in four descriptors under three stall mixes;",
             bytes_sent);
    $display("checked %0d placement items, %0d mismatches.",
             board.placements_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
